// File: rtl/lwfs_pkg.sv
// ----------------------------------------------------------------------------
// lwfs_pkg
// types and constants shared by the window fill sequencer modules
// ----------------------------------------------------------------------------
package lwfs_pkg;

   // controller command codes
   localparam logic [15:0] CMD_COLUMN_ADDR  = 16'h002A;
   localparam logic [15:0] CMD_ROW_ADDR     = 16'h002B;
   localparam logic [15:0] CMD_MEMORY_WRITE = 16'h002C;

   // saturation value of the repeat count
   localparam logic [16:0] REPEAT_MAX = 17'h1FFFF;

   // window queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one draw request
   typedef struct packed {
      logic        req_type;
      logic [15:0] x_start;
      logic [15:0] y_start;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [15:0] pixel_color;
   } lwfs_req_type;

   // one bus write
   typedef struct packed {
      logic        is_data;
      logic [15:0] bus_word;
      logic [16:0] repeat_count;
      logic        last_write;
   } lwfs_rsp_type;

   // a classified, clipped window ready to be sent
   typedef struct packed {
      logic [15:0] x0;
      logic [15:0] x1;
      logic [15:0] y0;
      logic [15:0] y1;
      logic [15:0] color;
      logic [16:0] count;
   } lwfs_window_type;

   // queue status seen by front and back
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } lwfs_qstat_type;

endpackage

// File: rtl/lcd_window_fill_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer
// turns dot and rectangle requests into display controller bus writes
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload          direction
//   request   start / busy         req_payload      in
//   result    rsp_strobe           rsp_payload      out
//
// a drawn request produces twelve writes, one per cycle, the first one after
// its transfer passes both front stages, the queue, the sequencer load and
// the output register
// the back sequencer sets the sustained rate, with no gap between the writes
// of successive requests
// dropped requests (off screen or empty) are accepted and emit nothing
// busy rises while two windows are held in the front stages and queue together
// synchronous reset clears all control state; the receiver cannot stall
// ----------------------------------------------------------------------------
module lcd_window_fill_sequencer #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 320
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lwfs_pkg::lwfs_req_type req_payload,
   output logic                   rsp_strobe,
   output lwfs_pkg::lwfs_rsp_type rsp_payload
);
   import lwfs_pkg::*;

   logic            push;
   logic            pop;
   lwfs_window_type push_window;
   lwfs_window_type head_window;
   lwfs_qstat_type  qstat;

   // classify, clip and count
   lwfs_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .push_window (push_window)
   );

   // window queue
   lwfs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_window (push_window),
      .pop         (pop),
      .head_window (head_window),
      .qstat       (qstat)
   );

   // bus write sequencer
   lwfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .head_window (head_window),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/lwfs_front.sv
// ----------------------------------------------------------------------------
// lwfs_front
// accepts requests, drops off-screen and empty ones, clips the far edges and
// forms the pixel count over two pipeline stages
// ----------------------------------------------------------------------------
module lwfs_front #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 320
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  lwfs_pkg::lwfs_req_type   req_payload,
   input  lwfs_pkg::lwfs_qstat_type qstat,
   output logic                     push,
   output lwfs_pkg::lwfs_window_type push_window
);
   import lwfs_pkg::*;

   localparam int XSPAN_W = $clog2(SCREEN_WIDTH + 1);
   localparam int YSPAN_W = $clog2(SCREEN_HEIGHT + 1);
   localparam int PROD_W  = XSPAN_W + YSPAN_W;

   localparam logic [15:0] X_LIMIT = 16'(SCREEN_WIDTH);
   localparam logic [15:0] Y_LIMIT = 16'(SCREEN_HEIGHT);
   localparam logic [15:0] X_LAST  = 16'(SCREEN_WIDTH - 1);
   localparam logic [15:0] Y_LAST  = 16'(SCREEN_HEIGHT - 1);

   logic               accept;
   logic               drawn;
   logic [16:0]        x_sum;
   logic [16:0]        y_sum;
   logic [15:0]        x_end;
   logic [15:0]        y_end;
   logic [15:0]        x_diff;
   logic [15:0]        y_diff;
   logic [QCNT_W:0]    inflight;

   // stage 1: clipped window and spans
   logic               s1_valid_ff, s1_valid_in;
   logic [15:0]        s1_x0_ff, s1_x1_ff, s1_y0_ff, s1_y1_ff, s1_color_ff;
   logic [XSPAN_W-1:0] s1_xspan_ff;
   logic [YSPAN_W-1:0] s1_yspan_ff;

   // stage 2: window with product
   logic               s2_valid_ff, s2_valid_in;
   logic [15:0]        s2_x0_ff, s2_x1_ff, s2_y0_ff, s2_y1_ff, s2_color_ff;
   logic [PROD_W-1:0]  s2_prod_ff;
   logic [31:0]        prod_ext;

   // credit check: every item in the pipe owns a queue slot
   assign inflight = (QCNT_W + 1)'(s1_valid_ff) + (QCNT_W + 1)'(s2_valid_ff)
                   + {1'b0, qstat.count};
   assign busy     = inflight >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept   = start && !busy;

   // classify and clip
   always_comb begin
      x_sum = {1'b0, req_payload.x_start} + {1'b0, req_payload.rect_width} - 17'd1;
      y_sum = {1'b0, req_payload.y_start} + {1'b0, req_payload.rect_height} - 17'd1;
      drawn = (req_payload.x_start < X_LIMIT) && (req_payload.y_start < Y_LIMIT)
           && (!req_payload.req_type
               || (req_payload.rect_width != 16'd0 && req_payload.rect_height != 16'd0));
      if (!req_payload.req_type) begin
         x_end = req_payload.x_start;
         y_end = req_payload.y_start;
      end else begin
         x_end = (x_sum >= {1'b0, X_LIMIT}) ? X_LAST : x_sum[15:0];
         y_end = (y_sum >= {1'b0, Y_LIMIT}) ? Y_LAST : y_sum[15:0];
      end
      x_diff = x_end - req_payload.x_start + 16'd1;
      y_diff = y_end - req_payload.y_start + 16'd1;
   end

   assign s1_valid_in = accept && drawn;
   assign s2_valid_in = s1_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_x0_ff    <= req_payload.x_start;
      s1_x1_ff    <= x_end;
      s1_y0_ff    <= req_payload.y_start;
      s1_y1_ff    <= y_end;
      s1_color_ff <= req_payload.pixel_color;
      s1_xspan_ff <= x_diff[XSPAN_W-1:0];
      s1_yspan_ff <= y_diff[YSPAN_W-1:0];
      s2_x0_ff    <= s1_x0_ff;
      s2_x1_ff    <= s1_x1_ff;
      s2_y0_ff    <= s1_y0_ff;
      s2_y1_ff    <= s1_y1_ff;
      s2_color_ff <= s1_color_ff;
      s2_prod_ff  <= PROD_W'(s1_xspan_ff) * PROD_W'(s1_yspan_ff);
   end

   // saturate the count and hand the window to the queue
   assign prod_ext = 32'(s2_prod_ff);
   assign push     = s2_valid_ff;
   always_comb begin
      push_window.x0    = s2_x0_ff;
      push_window.x1    = s2_x1_ff;
      push_window.y0    = s2_y0_ff;
      push_window.y1    = s2_y1_ff;
      push_window.color = s2_color_ff;
      push_window.count = (prod_ext > 32'(REPEAT_MAX)) ? REPEAT_MAX : prod_ext[16:0];
   end

endmodule

// File: rtl/lwfs_queue.sv
// ----------------------------------------------------------------------------
// lwfs_queue
// short window queue that decouples the front from the back
// ----------------------------------------------------------------------------
module lwfs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lwfs_pkg::lwfs_window_type push_window,
   input  logic                      pop,
   output lwfs_pkg::lwfs_window_type head_window,
   output lwfs_pkg::lwfs_qstat_type  qstat
);
   import lwfs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   lwfs_window_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_window;
      end
   end

   assign head_window = slot_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

   // no transfer into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)) || pop)
      else $error("window queue overflow");

   // no pop from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("window queue underflow");

   // occupancy follows the transfers
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == QCNT_W'($past(count_ff) + 1'b1))
      else $error("window queue count lost a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == QCNT_W'($past(count_ff) - 1'b1))
      else $error("window queue count lost a pop");

endmodule

// File: rtl/lwfs_back.sv
// ----------------------------------------------------------------------------
// lwfs_back
// sends one window as twelve bus writes, one per cycle, and moves straight
// on to the next queued window
// ----------------------------------------------------------------------------
module lwfs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lwfs_pkg::lwfs_qstat_type  qstat,
   input  lwfs_pkg::lwfs_window_type head_window,
   output logic                      pop,
   output logic                      rsp_strobe,
   output lwfs_pkg::lwfs_rsp_type    rsp_payload
);
   import lwfs_pkg::*;

   typedef enum logic [3:0] {
      BEAT_COL_CMD,
      BEAT_XS_HI,
      BEAT_XS_LO,
      BEAT_XE_HI,
      BEAT_XE_LO,
      BEAT_ROW_CMD,
      BEAT_YS_HI,
      BEAT_YS_LO,
      BEAT_YE_HI,
      BEAT_YE_LO,
      BEAT_MEM_CMD,
      BEAT_COLOR
   } beat_type;

   logic            active_ff;
   beat_type        beat_ff;
   lwfs_window_type cur_ff;
   logic            strobe_ff;
   lwfs_rsp_type    rsp_ff;
   lwfs_rsp_type    word;
   logic            done;

   // write for the current beat
   always_comb begin
      word.is_data      = 1'b1;
      word.bus_word     = 16'd0;
      word.repeat_count = 17'd1;
      word.last_write   = 1'b0;
      unique case (beat_ff)
         BEAT_COL_CMD: begin
            word.is_data  = 1'b0;
            word.bus_word = CMD_COLUMN_ADDR;
         end
         BEAT_XS_HI:   word.bus_word = {8'd0, cur_ff.x0[15:8]};
         BEAT_XS_LO:   word.bus_word = {8'd0, cur_ff.x0[7:0]};
         BEAT_XE_HI:   word.bus_word = {8'd0, cur_ff.x1[15:8]};
         BEAT_XE_LO:   word.bus_word = {8'd0, cur_ff.x1[7:0]};
         BEAT_ROW_CMD: begin
            word.is_data  = 1'b0;
            word.bus_word = CMD_ROW_ADDR;
         end
         BEAT_YS_HI:   word.bus_word = {8'd0, cur_ff.y0[15:8]};
         BEAT_YS_LO:   word.bus_word = {8'd0, cur_ff.y0[7:0]};
         BEAT_YE_HI:   word.bus_word = {8'd0, cur_ff.y1[15:8]};
         BEAT_YE_LO:   word.bus_word = {8'd0, cur_ff.y1[7:0]};
         BEAT_MEM_CMD: begin
            word.is_data  = 1'b0;
            word.bus_word = CMD_MEMORY_WRITE;
         end
         BEAT_COLOR: begin
            word.bus_word     = cur_ff.color;
            word.repeat_count = cur_ff.count;
            word.last_write   = 1'b1;
         end
         default: word.bus_word = 16'd0;
      endcase
   end

   // take the next window when idle or on the final beat
   assign done = !active_ff || (beat_ff == BEAT_COLOR);
   assign pop  = done && !qstat.empty;

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff   <= BEAT_COL_CMD;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= active_ff;
         if (pop) begin
            active_ff <= 1'b1;
            beat_ff   <= BEAT_COL_CMD;
         end else if (done) begin
            active_ff <= 1'b0;
            beat_ff   <= BEAT_COL_CMD;
         end else begin
            beat_ff   <= beat_type'(beat_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= word;
      if (pop) begin
         cur_ff <= head_window;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
